/* rtl/tea_pkg.sv */
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared types and constants for the TEA round pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUND_W    = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

    // reset key: "1234567890abcdek" as little-endian words
    localparam logic [WORD_W-1:0]  KEY0_RST   = 32'h3433_3231;
    localparam logic [WORD_W-1:0]  KEY1_RST   = 32'h3837_3635;
    localparam logic [WORD_W-1:0]  KEY2_RST   = 32'h6261_3039;
    localparam logic [WORD_W-1:0]  KEY3_RST   = 32'h6b65_6463;
    localparam logic [ROUND_W-1:0] ROUNDS_RST = 7'd16;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // one block in flight between cells
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic [WORD_W-1:0]  y;
        logic [WORD_W-1:0]  z;
        logic [WORD_W-1:0]  sum;
        logic [ROUND_W-1:0] left;
    } t_blk;

endpackage

/* rtl/tea_cell.sv */
// ----------------------------------------------------------------------------
// TEA half-round cell
// Updates one half of the block per cycle and hands the block to the next
// cell. Even cells and odd cells together form one full round.
// ----------------------------------------------------------------------------
module tea_cell import tea_pkg::*; #(
    parameter bit ODD = 1'b0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_key i_key,
    input  t_blk i_blk,
    output t_blk o_blk
);

    t_blk              r_blk;
    t_blk              n_blk;
    logic              active;
    logic              upd_z;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] tgt;
    logic [WORD_W-1:0] kl;
    logic [WORD_W-1:0] kr;
    logic [WORD_W-1:0] mix;

    assign active = (i_blk.left != '0);
    // encrypt: even cell updates y, odd updates z; decrypt reverses the order
    assign upd_z  = ODD ^ i_blk.mode;
    assign src    = upd_z ? i_blk.y : i_blk.z;
    assign tgt    = upd_z ? i_blk.z : i_blk.y;
    assign kl     = upd_z ? i_key.k2 : i_key.k0;
    assign kr     = upd_z ? i_key.k3 : i_key.k1;
    assign mix    = ((src << 4) + kl) ^ (src + i_blk.sum) ^ ((src >> 5) + kr);

    always_comb begin
        n_blk = i_blk;
        if (active) begin
            if (upd_z) begin
                n_blk.z = i_blk.mode ? (tgt - mix) : (tgt + mix);
            end else begin
                n_blk.y = i_blk.mode ? (tgt - mix) : (tgt + mix);
            end
            // step the sum for the next round at the end of this one
            if (ODD) begin
                n_blk.sum  = i_blk.mode ? (i_blk.sum - TEA_DELTA) : (i_blk.sum + TEA_DELTA);
                n_blk.left = i_blk.left - ROUND_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk.valid <= 1'b0;
        end else begin
            r_blk.valid <= n_blk.valid;
        end
        r_blk.mode <= n_blk.mode;
        r_blk.y    <= n_blk.y;
        r_blk.z    <= n_blk.z;
        r_blk.sum  <= n_blk.sum;
        r_blk.left <= n_blk.left;
    end

    assign o_blk = r_blk;

endmodule

/* rtl/tea_block_cipher.sv */
// ----------------------------------------------------------------------------
// TEA block cipher
// Encrypts or decrypts 64-bit blocks under a 128-bit key through a chain of
// half-round cells, one block accepted per cycle while busy is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_mode, i_half_first and i_half_second and raise start; the
//   block transfers at a rising edge with start high and busy low. busy is
//   high only for the cycle right after reset, so a new block can transfer
//   in every cycle after that.
//   Output: o_valid marks one cycle with o_out_first / o_out_second; the
//   result transfers at the edge that ends that cycle. The receiver cannot
//   stall, and results come out in the order blocks went in.
//   Pipeline: a transferred block passes the input register and then the
//   2*MAX_ROUNDS half-round cells; each cell updates one half per cycle.
//   Blocks needing fewer rounds pass the spare cells unchanged, so the
//   time to a result does not depend on the round count. Throughput is one
//   block per cycle while busy is low.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high (0..3 key words, 4 round count); only while no block is in flight.
//   Round counts above MAX_ROUNDS saturate; zero passes the block through.
//   Reset: loads the default key and 16 rounds and drops all blocks.
// ----------------------------------------------------------------------------
module tea_block_cipher import tea_pkg::*; #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [WORD_W-1:0]    i_half_first,
    input  logic [WORD_W-1:0]    i_half_second,
    output logic                 o_valid,
    output logic [WORD_W-1:0]    o_out_first,
    output logic [WORD_W-1:0]    o_out_second
);

    localparam int NCELL = 2 * MAX_ROUNDS;

    t_key               r_key;
    logic [ROUND_W-1:0] r_rounds;
    logic [WORD_W-1:0]  r_dec_sum;
    logic               r_busy;
    logic [ROUND_W-1:0] n_rounds;
    t_blk               r_in;
    t_blk               n_in;
    t_blk               chain [NCELL+1];

    // saturate the round count on write; the register write below precomputes the decrypt start sum
    always_comb begin
        if (i_cfg_data[ROUND_W-1:0] > ROUND_W'(MAX_ROUNDS)) begin
            n_rounds = ROUND_W'(MAX_ROUNDS);
        end else begin
            n_rounds = i_cfg_data[ROUND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k0  <= KEY0_RST;
            r_key.k1  <= KEY1_RST;
            r_key.k2  <= KEY2_RST;
            r_key.k3  <= KEY3_RST;
            r_rounds  <= ROUNDS_RST;
            r_dec_sum <= TEA_DELTA * WORD_W'(ROUNDS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY0:   r_key.k0 <= i_cfg_data;
                CFG_KEY1:   r_key.k1 <= i_cfg_data;
                CFG_KEY2:   r_key.k2 <= i_cfg_data;
                CFG_KEY3:   r_key.k3 <= i_cfg_data;
                CFG_ROUNDS: begin
                    r_rounds  <= n_rounds;
                    r_dec_sum <= TEA_DELTA * WORD_W'(n_rounds);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    always_comb begin
        n_in.valid = start && !r_busy;
        n_in.mode  = i_mode;
        n_in.y     = i_half_first;
        n_in.z     = i_half_second;
        // encrypt uses delta in its first round; decrypt starts at delta*rounds
        n_in.sum   = i_mode ? r_dec_sum : TEA_DELTA;
        n_in.left  = r_rounds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= n_in.valid;
        end
        r_in.mode <= n_in.mode;
        r_in.y    <= n_in.y;
        r_in.z    <= n_in.z;
        r_in.sum  <= n_in.sum;
        r_in.left <= n_in.left;
    end

    assign chain[0] = r_in;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tea_cell #(
            .ODD (1'(g % 2))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_blk   (chain[g]),
            .o_blk   (chain[g+1])
        );
    end

    assign o_valid      = chain[NCELL].valid;
    assign o_out_first  = chain[NCELL].y;
    assign o_out_second = chain[NCELL].z;

endmodule
